### sv/bfcs_pkg.sv
// Shared constants and types for the back-face culling and flat shading block.
`default_nettype none
package bfcs_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int NUM_COORDS  = 9;
    localparam int EW          = COORD_WIDTH + 1;
    localparam int PW          = 2 * EW;
    localparam int NW          = PW + 1;
    localparam int NLO         = 18;
    localparam int NHI         = NW - NLO;
    localparam int DW          = COORD_WIDTH + NW + 2;
    localparam int MAG_BITS    = 23;
    localparam int SQ_W        = 2 * MAG_BITS;
    localparam int S_W         = SQ_W + 2;
    localparam int SH_W        = $clog2(NW);
    localparam int EYE_Z       = 5;
    localparam int IN_W        = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_W       = 40;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam logic [63:0] NEAR_ZERO_SQ =
        (4 * FRAC_BITS - 8 < 0) ? 64'd0 : ((64'd1 << (4 * FRAC_BITS - 8)) / 64'd390625);
    localparam logic [15:0] FULL_SQ = 16'd65025;

    typedef enum logic [1:0] {
        REG_RED   = 2'd0,
        REG_GREEN = 2'd1,
        REG_BLUE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                 vis;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
    } face_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;
endpackage
`default_nettype wire

### sv/bfcs_front.sv
// Front end: accepts triangles, forms the face normal and the visibility test.
`default_nettype none
module bfcs_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [bfcs_pkg::IN_W-1:0]  in_data,
    input  wire logic                       q_full,
    output logic                            q_push,
    output bfcs_pkg::face_t                 q_data
);
    localparam int CW  = bfcs_pkg::COORD_WIDTH;
    localparam int EW  = bfcs_pkg::EW;
    localparam int PW  = bfcs_pkg::PW;
    localparam int NW  = bfcs_pkg::NW;
    localparam int NLO = bfcs_pkg::NLO;
    localparam int NHI = bfcs_pkg::NHI;
    localparam int DW  = bfcs_pkg::DW;
    localparam logic signed [EW-1:0] EYE_OFS = EW'(bfcs_pkg::EYE_Z * (2 ** bfcs_pkg::FRAC_BITS));

    logic [4:0] vld_reg;
    logic       adv;

    logic signed [CW-1:0] c [0:8];
    logic signed [EW-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [CW-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic signed [EW-1:0] vz1_reg, vz2_reg, vz3_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [NW-1:0] nx3_reg, ny3_reg, nz3_reg, nx4_reg, ny4_reg, nz4_reg;
    logic signed [CW+NLO:0]   lx_reg, ly_reg;
    logic signed [EW+NLO:0]   lz_reg;
    logic signed [CW+NHI-1:0] hx_reg, hy_reg;
    logic signed [EW+NHI-1:0] hz_reg;
    logic signed [DW-1:0] dot;
    bfcs_pkg::face_t      out_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            c[i] = in_data[i*CW +: CW];
        end
    end

    assign adv      = !(vld_reg[4] && q_full);
    assign in_ready = adv;
    assign q_push   = vld_reg[4] && adv;
    assign q_data   = out_reg;

    always_comb begin
        dot = (DW'(hx_reg) <<< NLO) + DW'(lx_reg)
            + (DW'(hy_reg) <<< NLO) + DW'(ly_reg)
            + (DW'(hz_reg) <<< NLO) + DW'(lz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1x_reg <= EW'(c[3]) - EW'(c[0]);
            e1y_reg <= EW'(c[4]) - EW'(c[1]);
            e1z_reg <= EW'(c[5]) - EW'(c[2]);
            e2x_reg <= EW'(c[6]) - EW'(c[0]);
            e2y_reg <= EW'(c[7]) - EW'(c[1]);
            e2z_reg <= EW'(c[8]) - EW'(c[2]);
            ax1_reg <= c[0];
            ay1_reg <= c[1];
            vz1_reg <= EW'(c[2]) - EYE_OFS;

            p0_reg  <= e1y_reg * e2z_reg;
            p1_reg  <= e1z_reg * e2y_reg;
            p2_reg  <= e1z_reg * e2x_reg;
            p3_reg  <= e1x_reg * e2z_reg;
            p4_reg  <= e1x_reg * e2y_reg;
            p5_reg  <= e1y_reg * e2x_reg;
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            vz2_reg <= vz1_reg;

            nx3_reg <= NW'(p0_reg) - NW'(p1_reg);
            ny3_reg <= NW'(p2_reg) - NW'(p3_reg);
            nz3_reg <= NW'(p4_reg) - NW'(p5_reg);
            ax3_reg <= ax2_reg;
            ay3_reg <= ay2_reg;
            vz3_reg <= vz2_reg;

            lx_reg  <= ax3_reg * $signed({1'b0, nx3_reg[NLO-1:0]});
            ly_reg  <= ay3_reg * $signed({1'b0, ny3_reg[NLO-1:0]});
            lz_reg  <= vz3_reg * $signed({1'b0, nz3_reg[NLO-1:0]});
            hx_reg  <= ax3_reg * $signed(nx3_reg[NW-1:NLO]);
            hy_reg  <= ay3_reg * $signed(ny3_reg[NW-1:NLO]);
            hz_reg  <= vz3_reg * $signed(nz3_reg[NW-1:NLO]);
            nx4_reg <= nx3_reg;
            ny4_reg <= ny3_reg;
            nz4_reg <= nz3_reg;

            out_reg.vis <= dot[DW-1];
            out_reg.nx  <= nx4_reg;
            out_reg.ny  <= ny4_reg;
            out_reg.nz  <= nz4_reg;
        end
    end
endmodule
`default_nettype wire

### sv/bfcs_fifo.sv
// Short queue that decouples the front end from the shading back end.
`default_nettype none
module bfcs_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire bfcs_pkg::face_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output bfcs_pkg::face_t      pop_data,
    output logic                 empty
);
    localparam int AW = bfcs_pkg::FIFO_AW;

    bfcs_pkg::face_t mem [0:bfcs_pkg::FIFO_DEPTH-1];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full     = (count_reg == (AW+1)'(bfcs_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

### sv/bfcs_back.sv
// Back end: normal length normalization, intensity search and color scaling.
`default_nettype none
module bfcs_back (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     q_empty,
    output logic                          q_pop,
    input  wire bfcs_pkg::face_t          q_data,
    input  wire bfcs_pkg::color_t         color,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [bfcs_pkg::OUT_W-1:0]    out_data
);
    localparam int NW   = bfcs_pkg::NW;
    localparam int MB   = bfcs_pkg::MAG_BITS;
    localparam int SQ_W = bfcs_pkg::SQ_W;
    localparam int S_W  = bfcs_pkg::S_W;
    localparam int SH_W = bfcs_pkg::SH_W;
    localparam int OUT_W_L = bfcs_pkg::OUT_W;

    logic adv;
    logic v1_reg, v2_reg, out_valid_reg;
    logic [8:0] sv_reg;

    logic [NW-1:0]   mx, my, mz, mor;
    logic [SH_W-1:0] sh;
    logic [MB-1:0]   mx1_reg, my1_reg, mz1_reg;
    logic            zero1_reg, nosh1_reg, zero2_reg, nosh2_reg;
    logic            vis1_reg, vis2_reg;
    logic [SQ_W-1:0] sx2_reg, sy2_reg, sz2_reg;
    logic [S_W-1:0]  ssum;

    logic [7:0]  k_reg   [0:8];
    logic [63:0] ks_reg  [0:8];
    logic [63:0] p_reg   [0:8];
    logic [63:0] s_reg   [0:8];
    logic [63:0] r_reg   [0:8];
    logic        z_reg   [0:8];
    logic        vis_reg [0:8];

    logic [7:0]  kf;
    logic [15:0] xr, xg, xb;
    logic [OUT_W_L-1:0] out_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign q_pop     = !q_empty && adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        mx  = q_data.nx[NW-1] ? NW'(-q_data.nx) : NW'(q_data.nx);
        my  = q_data.ny[NW-1] ? NW'(-q_data.ny) : NW'(q_data.ny);
        mz  = NW'(q_data.nz);
        mor = mx | my | mz;
        sh  = '0;
        for (int i = MB; i < NW; i++) begin
            if (mor[i]) begin
                sh = SH_W'(i - MB + 1);
            end
        end
    end

    assign ssum = S_W'(sx2_reg) + S_W'(sy2_reg) + S_W'(sz2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            sv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= q_pop;
            v2_reg        <= v1_reg;
            sv_reg        <= {sv_reg[7:0], v2_reg};
            out_valid_reg <= sv_reg[8];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mx1_reg   <= MB'(mx >> sh);
            my1_reg   <= MB'(my >> sh);
            mz1_reg   <= MB'(mz >> sh);
            zero1_reg <= !q_data.vis || q_data.nz[NW-1] || (q_data.nz == '0);
            nosh1_reg <= (sh == '0);
            vis1_reg  <= q_data.vis;

            sx2_reg   <= mx1_reg * mx1_reg;
            sy2_reg   <= my1_reg * my1_reg;
            sz2_reg   <= mz1_reg * mz1_reg;
            zero2_reg <= zero1_reg;
            nosh2_reg <= nosh1_reg;
            vis2_reg  <= vis1_reg;

            k_reg[0]   <= '0;
            ks_reg[0]  <= '0;
            p_reg[0]   <= '0;
            s_reg[0]   <= 64'(ssum);
            r_reg[0]   <= (64'(sz2_reg) << 16) - (64'(sz2_reg) << 9) + 64'(sz2_reg);
            z_reg[0]   <= zero2_reg || (nosh2_reg && (64'(ssum) <= bfcs_pkg::NEAR_ZERO_SQ));
            vis_reg[0] <= vis2_reg;
        end
    end

    for (genvar j = 0; j < 8; j++) begin : g_step
        localparam int B = 7 - j;
        logic [63:0] sb, ts, tp;
        logic        take;
        always_comb begin
            sb   = s_reg[j] << B;
            ts   = ks_reg[j] + sb;
            tp   = p_reg[j] + (((ks_reg[j] << 1) + sb) << B);
            take = (tp <= r_reg[j]);
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                k_reg[j+1]   <= take ? (k_reg[j] | 8'(1 << B)) : k_reg[j];
                ks_reg[j+1]  <= take ? ts : ks_reg[j];
                p_reg[j+1]   <= take ? tp : p_reg[j];
                s_reg[j+1]   <= s_reg[j];
                r_reg[j+1]   <= r_reg[j];
                z_reg[j+1]   <= z_reg[j];
                vis_reg[j+1] <= vis_reg[j];
            end
        end
    end

    always_comb begin
        kf = z_reg[8] ? 8'd0 : k_reg[8];
        xr = color.red   * kf;
        xg = color.green * kf;
        xb = color.blue  * kf;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg[0]     <= vis_reg[8];
            out_reg[8:1]   <= kf;
            out_reg[16:9]  <= 8'((xr + 16'd1 + (xr >> 8)) >> 8);
            out_reg[24:17] <= 8'((xg + 16'd1 + (xg >> 8)) >> 8);
            out_reg[32:25] <= 8'((xb + 16'd1 + (xb >> 8)) >> 8);
            out_reg[39:33] <= '0;
        end
    end
endmodule
`default_nettype wire

### sv/backface_cull_flat_shade.sv
// Top level of the back-face culling and flat shading block.
// Throughput: one triangle per cycle while the output is not stalled, set by the fully pipelined normal,
// dot product and eight-step intensity search.
// A four-entry queue sits between the front end and the back end.
// Synchronous active-low reset empties the pipeline and sets all colors to 255.
`default_nettype none
module backface_cull_flat_shade (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
    input  wire logic [bfcs_pkg::IN_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // visible, intensity, shaded_red, shaded_green, shaded_blue
    output logic [bfcs_pkg::OUT_W-1:0]     m_tdata,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [7:0]                cfg_data
);
    bfcs_pkg::color_t color_reg;
    bfcs_pkg::face_t  push_data, pop_data;
    logic             push, pop, full, empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= '{red: 8'd255, green: 8'd255, blue: 8'd255};
        end else if (cfg_valid) begin
            case (cfg_index)
                bfcs_pkg::REG_RED:   color_reg.red   <= cfg_data;
                bfcs_pkg::REG_GREEN: color_reg.green <= cfg_data;
                bfcs_pkg::REG_BLUE:  color_reg.blue  <= cfg_data;
                default: ;
            endcase
        end
    end

    bfcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    bfcs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    bfcs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (empty),
        .q_pop     (pop),
        .q_data    (pop_data),
        .color     (color_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );
endmodule
`default_nettype wire

### sv/bfcs_checker.sv
// Port-level checks for the culling and shading block, bound to the top level.
`default_nettype none
module bfcs_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [bfcs_pkg::OUT_W-1:0] m_tdata
);
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid right after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result transfer changed.");

    a_culled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == '0)
        else $error("Culled face carries nonzero shading.");

    a_dark_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8:1] == '0 |-> m_tdata[32:9] == '0)
        else $error("Zero intensity with nonzero color.");
endmodule

bind backface_cull_flat_shade bfcs_checker u_bfcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### verif/tb.sv
// Testbench for the back-face culling and flat shading block.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES = 6;
    localparam int FACES_PER_PHASE = 300;

    class shade_scoreboard;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [39:0] pending[$];
        int          errors;

        function new();
            red = 8'd255;
            green = 8'd255;
            blue = 8'd255;
            errors = 0;
        endfunction

        function logic [7:0] lambert(longint nx, longint ny, longint nz);
            logic [63:0] mx, my, mz, s, t;
            logic [7:0]  k;
            if (nz <= 0) return 8'd0;
            mx = (nx < 0) ? -nx : nx;
            my = (ny < 0) ? -ny : ny;
            mz = nz;
            if (mx < (64'd1 << bfcs_pkg::MAG_BITS) && my < (64'd1 << bfcs_pkg::MAG_BITS) &&
                mz < (64'd1 << bfcs_pkg::MAG_BITS)) begin
                s = mx * mx + my * my + mz * mz;
                if (s <= bfcs_pkg::NEAR_ZERO_SQ) return 8'd0;
            end else begin
                while (mx >= (64'd1 << bfcs_pkg::MAG_BITS) ||
                       my >= (64'd1 << bfcs_pkg::MAG_BITS) ||
                       mz >= (64'd1 << bfcs_pkg::MAG_BITS)) begin
                    mx = mx >> 1;
                    my = my >> 1;
                    mz = mz >> 1;
                end
                s = mx * mx + my * my + mz * mz;
            end
            k = 8'd0;
            for (int b = 7; b >= 0; b--) begin
                t = 64'(k | (8'd1 << b));
                if (t * t * s <= 64'(bfcs_pkg::FULL_SQ) * mz * mz) k = t[7:0];
            end
            return k;
        endfunction

        function void note_face(logic [bfcs_pkg::IN_W-1:0] d);
            longint c[9];
            longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, dot;
            logic [7:0] k;
            logic       vis;
            for (int i = 0; i < 9; i++) c[i] = $signed(d[i*16 +: 16]);
            e1x = c[3] - c[0]; e1y = c[4] - c[1]; e1z = c[5] - c[2];
            e2x = c[6] - c[0]; e2y = c[7] - c[1]; e2z = c[8] - c[2];
            nx = e1y * e2z - e1z * e2y;
            ny = e1z * e2x - e1x * e2z;
            nz = e1x * e2y - e1y * e2x;
            dot = c[0] * nx + c[1] * ny
                + (c[2] - (bfcs_pkg::EYE_Z << bfcs_pkg::FRAC_BITS)) * nz;
            vis = dot < 0;
            k = vis ? lambert(nx, ny, nz) : 8'd0;
            pending.push_back({7'd0, 8'((16'(blue) * k) / 255), 8'((16'(green) * k) / 255),
                               8'((16'(red) * k) / 255), k, vis});
        endfunction

        function void check_result(logic [39:0] got);
            int lo[5] = '{0, 1, 9, 17, 25};
            int wd[5] = '{1, 8, 8, 8, 8};
            logic [39:0] want, mask;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int f = 0; f < 5; f++) begin
                mask = (40'd1 << wd[f]) - 1;
                if (((want >> lo[f]) & mask) != ((got >> lo[f]) & mask)) begin
                    $display("%0t: field %0d expected %0d actual %0d", $time, f,
                             (want >> lo[f]) & mask, (got >> lo[f]) & mask);
                    errors++;
                end
            end
        endfunction
    endclass

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [bfcs_pkg::IN_W-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [bfcs_pkg::OUT_W-1:0] m_tdata;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [1:0]      cfg_index = bfcs_pkg::REG_RED;
    logic [7:0]      cfg_data = '0;

    shade_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int cyc = 0;

    backface_cull_flat_shade dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        cyc++;
        if (cyc % 200 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom % 4) != 0;
            2: m_tready <= (cyc % 16) < 5;
            default: m_tready <= ($urandom % 5) == 0;
        endcase
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_color(logic [1:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bfcs_pkg::REG_RED: sb.red = val;
            bfcs_pkg::REG_GREEN: sb.green = val;
            bfcs_pkg::REG_BLUE: sb.blue = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_face(logic [bfcs_pkg::IN_W-1:0] d);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = d;
        do @(posedge aclk); while (!s_tready);
        sb.note_face(d);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom % 4 == 0) ? 400 : $urandom_range(1, 40);
            if ($urandom % 3 != 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge aclk);
            end
        end
    endtask

    task automatic send_tri(int ax, int ay, int az, int bx, int by, int bz,
                            int cx, int cy, int cz);
        send_face({16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by), 16'(bx),
                   16'(az), 16'(ay), 16'(ax)});
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (sb.pending.size() == 0);
        repeat (30) @(posedge aclk);
    endtask

    function automatic logic [bfcs_pkg::IN_W-1:0] random_face();
        logic [bfcs_pkg::IN_W-1:0] d;
        int span;
        int base[3];
        span = ($urandom % 4 == 0) ? 32768 : (1 << $urandom_range(1, 11));
        for (int j = 0; j < 3; j++)
            base[j] = (span == 32768) ? 0 : $urandom_range(0, 8000) - 4000;
        for (int i = 0; i < 9; i++)
            d[i*16 +: 16] = (span == 32768) ? 16'($urandom)
                          : 16'(base[i % 3] + $urandom_range(0, 2 * span) - span);
        return d;
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_tri(0, 0, 0, 0, 256, 0, 256, 0, 0);
        send_tri(-256, 0, 0, -256, 256, 0, -256, 0, 256);
        send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_tri(0, 0, 1280, 256, 0, 1280, 0, 256, 1280);
        send_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
        send_tri(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767);
        send_tri(-32768, -32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
        send_tri(0, 0, -32768, 32767, 0, 0, 0, 32767, 32767);
        send_tri(100, 50, 0, 400, 80, 300, 120, 500, -200);
        send_face({bfcs_pkg::IN_W{1'b1}});
        send_face({9{16'h5555}});
        send_face({9{16'hAAAA}});
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_color(bfcs_pkg::REG_RED, 8'd0);
                    write_color(bfcs_pkg::REG_GREEN, 8'd0);
                    write_color(bfcs_pkg::REG_BLUE, 8'd0);
                end
                1: begin
                    write_color(bfcs_pkg::REG_RED, 8'd255);
                    write_color(bfcs_pkg::REG_GREEN, 8'd255);
                    write_color(bfcs_pkg::REG_BLUE, 8'd255);
                end
                2: begin
                    write_color(bfcs_pkg::REG_RED, 8'd1);
                    write_color(bfcs_pkg::REG_GREEN, 8'd128);
                    write_color(bfcs_pkg::REG_BLUE, 8'd254);
                    write_color(REG_NONE, 8'd0);
                end
                default: begin
                    write_color(bfcs_pkg::REG_RED, 8'($urandom));
                    write_color(bfcs_pkg::REG_GREEN, 8'($urandom));
                    write_color(bfcs_pkg::REG_BLUE, 8'($urandom));
                    write_color(REG_NONE, 8'($urandom));
                end
            endcase
            send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);
            send_tri(0, 0, 0, 300, 20, 10, 40, 280, 90);
            for (int i = 0; i < FACES_PER_PHASE; i++) send_face(random_face());
            drain();
        end

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
sv/bfcs_pkg.sv
sv/bfcs_front.sv
sv/bfcs_fifo.sv
sv/bfcs_back.sv
sv/backface_cull_flat_shade.sv
sv/bfcs_checker.sv
verif/tb.sv
